// ===== hdl/bwmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bwmt_pkg;

    // request kinds
    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_UNMAP = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STATE = 2'd1;
    localparam logic [1:0] ST_PARAM = 2'd2;

    // window layout
    localparam logic [31:0] WIN_BASE    = 32'h0100_0000;
    localparam logic [11:0] WIN_BASE_MB = 12'h010;
    localparam int          MB_SHIFT    = 20;

    typedef struct packed {
        logic        kind;
        logic [11:0] base;     // bus address bits 31..20
        logic [19:0] off;      // bus address bits 19..0
        logic [11:0] idx;      // window pointer slot, before range check
        logic        idx_ok;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] window_address;
        logic        program_valid;
        logic [4:0]  program_slot;
        logic [11:0] program_base;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_COMMIT
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/bwmt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwmt_front #(
    parameter int NUM_SLOTS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic          i_kind,
    input  wire logic [31:0]   i_bus_address,
    input  wire logic [31:0]   i_window_pointer,
    output logic               o_cmd_valid,
    output bwmt_pkg::t_cmd     o_cmd,
    input  wire logic          i_take
);
    import bwmt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       cls;
    logic       push_ok;
    logic       take_ok;

    // classify the incoming word before it is queued
    always_comb begin
        cls.kind   = i_kind;
        cls.base   = i_bus_address[31:20];
        cls.off    = i_bus_address[19:0];
        cls.idx    = i_window_pointer[31:20] - WIN_BASE_MB;
        cls.idx_ok = (cls.idx < 12'(NUM_SLOTS));
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_take && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (push_ok && !take_ok) begin
            n_count = r_count + 2'd1;
        end else if (!push_ok && take_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (take_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bwmt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwmt_back #(
    parameter int NUM_SLOTS = 32,
    parameter int REF_BITS  = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire bwmt_pkg::t_cmd i_cmd,
    output logic               o_take,
    input  wire logic          i_pop,
    output logic               o_res_valid,
    output bwmt_pkg::t_result  o_res
);
    import bwmt_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    t_back_state         r_state;
    t_back_state         n_state;
    t_cmd                r_cmd;
    logic [11:0]         r_base [NUM_SLOTS];
    logic [REF_BITS-1:0] r_refs [NUM_SLOTS];
    logic                r_ready;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic                r_found;
    logic                n_found;
    logic [11:0]         r_hit_base;
    logic [11:0]         n_hit_base;
    logic [REF_BITS-1:0] r_hit_refs;
    logic [REF_BITS-1:0] n_hit_refs;
    logic                r_out_valid;
    t_result             r_out;
    t_result             n_out;
    logic                commit_go;
    logic                commit_fire;
    logic                wr_en;
    logic [11:0]         wr_base;
    logic [REF_BITS-1:0] wr_refs;

    // search: first free or matching slot for a map, pointer slot for an unmap
    always_comb begin
        n_found = 1'b0;
        n_slot  = '0;
        if (r_cmd.kind == KIND_MAP) begin
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                if ((r_base[i] == 12'h000 && r_refs[i] == '0) || r_base[i] == r_cmd.base) begin
                    n_found = 1'b1;
                    n_slot  = SLOT_W'(i);
                end
            end
        end else begin
            n_found = r_cmd.idx_ok;
            n_slot  = r_cmd.idx[SLOT_W-1:0];
        end
    end

    always_comb begin
        n_hit_base = '0;
        n_hit_refs = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (n_slot == SLOT_W'(i)) begin
                n_hit_base = r_base[i];
                n_hit_refs = r_refs[i];
            end
        end
    end

    // commit: result word and slot update from the registered search
    always_comb begin
        n_out   = '0;
        wr_en   = 1'b0;
        wr_base = r_hit_base;
        wr_refs = r_hit_refs;
        if (r_cmd.kind == KIND_MAP) begin
            if (!r_found || r_hit_refs == REF_MAX) begin
                n_out.status = ST_STATE;
            end else begin
                n_out.status = ST_OK;
                wr_en        = 1'b1;
                wr_refs      = r_hit_refs + REF_BITS'(1);
                if (r_hit_base == 12'h000) begin
                    wr_base             = r_cmd.base;
                    n_out.program_valid = 1'b1;
                    n_out.program_slot  = 5'(r_slot);
                    n_out.program_base  = r_cmd.base;
                end
                n_out.window_address = WIN_BASE + (32'(r_slot) << MB_SHIFT)
                                     + 32'(r_cmd.off);
            end
        end else begin
            if (!r_ready) begin
                n_out.status = ST_STATE;
            end else if (!r_found || r_hit_refs == '0) begin
                n_out.status = ST_PARAM;
            end else begin
                n_out.status = ST_OK;
                wr_en        = 1'b1;
                wr_refs      = r_hit_refs - REF_BITS'(1);
                if (r_hit_refs == REF_BITS'(1)) begin
                    wr_base             = 12'h000;
                    n_out.program_valid = 1'b1;
                    n_out.program_slot  = 5'(r_slot);
                end
            end
        end
    end

    assign commit_go   = !r_out_valid || i_pop;
    assign commit_fire = (r_state == BK_COMMIT) && commit_go;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = BK_SEARCH;
                end
            end
            BK_SEARCH: begin
                n_state = BK_COMMIT;
            end
            BK_COMMIT: begin
                if (commit_go) begin
                    n_state = i_cmd_valid ? BK_SEARCH : BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            BK_IDLE:   o_take = i_cmd_valid;
            BK_COMMIT: o_take = commit_go && i_cmd_valid;
            default:   o_take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_base[i] <= '0;
                r_refs[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (commit_fire) begin
                r_out_valid <= 1'b1;
                if (r_cmd.kind == KIND_MAP) begin
                    r_ready <= 1'b1;
                end
                if (wr_en) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (r_slot == SLOT_W'(i)) begin
                            r_base[i] <= wr_base;
                            r_refs[i] <= wr_refs;
                        end
                    end
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == BK_SEARCH) begin
            r_found    <= n_found;
            r_slot     <= n_slot;
            r_hit_base <= n_hit_base;
            r_hit_refs <= n_hit_refs;
        end
        if (commit_fire) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ===== hdl/bus_window_map_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// request   in         push / full          i_kind, i_bus_address, i_window_pointer
// result    out        empty / pop          o_status, o_window_address,
//                                           o_program_valid, o_program_slot, o_program_base
//
// each request passes the table engine in a search step, for the parallel slot
// compare and priority pick, then a commit step, for the count update and result write
// a taken request is registered as the command, then its search, then the result word
// a two-word queue sits between request classification and the table engine
// a held result stalls the engine in its update step; requests still queue
// synchronous reset clears all slot bases and counts at once, no sweep needed

module bus_window_map_table #(
    parameter int NUM_SLOTS = 32,
    parameter int REF_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_bus_address,
    input  wire logic [31:0] i_window_pointer,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic [31:0]      o_window_address,
    output logic             o_program_valid,
    output logic [4:0]       o_program_slot,
    output logic [11:0]      o_program_base
);
    import bwmt_pkg::*;

    logic    cmd_valid;
    t_cmd    cmd;
    logic    take;
    logic    res_valid;
    t_result res;

    bwmt_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_kind          (i_kind),
        .i_bus_address   (i_bus_address),
        .i_window_pointer(i_window_pointer),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_take          (take)
    );

    bwmt_back #(
        .NUM_SLOTS(NUM_SLOTS),
        .REF_BITS (REF_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_take     (take),
        .i_pop      (pop),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    assign empty            = !res_valid;
    assign o_status         = res.status;
    assign o_window_address = res.window_address;
    assign o_program_valid  = res.program_valid;
    assign o_program_slot   = res.program_slot;
    assign o_program_base   = res.program_base;

    // after a word is accepted the engine always sees a valid command on the next cycle
    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> cmd_valid)
        else $error("accepted request lost in queue");

    a_failed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ST_OK |-> o_window_address == 32'h0 && !o_program_valid)
        else $error("failed request carries a window or programming");

    a_no_prog_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_program_valid |-> o_program_slot == 5'd0 && o_program_base == 12'h0)
        else $error("programming fields set without programming");

    // a successful map always returns a non-zero window, so this is a release
    a_unmap_prog_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_program_valid && o_window_address == 32'h0 && o_status == ST_OK
        |-> o_program_base == 12'h0)
        else $error("release programmed a non-zero base");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_window_address) && $stable(o_status))
        else $error("held result changed before pop");

endmodule

`default_nettype wire
